@@ src/tcr_pkg.sv @@
// ----------------------------------------------------------------------------
// tcr_pkg
// Shared widths and types for the triangle circumradius pipeline.
// ----------------------------------------------------------------------------
package tcr_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned RADIUS_W        = 32;
  localparam int unsigned QUO_W           = 2 * RADIUS_W;

  // status that travels beside each item
  typedef struct packed {
    logic valid;
    logic degen;
  } tcr_ctl_t;

endpackage

@@ src/tcr_root.sv @@
// ----------------------------------------------------------------------------
// tcr_root
// Back end: squared radius quotient by restoring division, then integer
// square root one bit per stage, with saturation and output register.
// ----------------------------------------------------------------------------
module tcr_root
  import tcr_pkg::*;
#(
  parameter int unsigned NUM_W = 201,
  parameter int unsigned DEN_W = 136
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  tcr_ctl_t            ctl_i,
  input  logic [NUM_W-1:0]    num_i,
  input  logic [DEN_W-1:0]    den_i,
  output tcr_ctl_t            ctl_o,
  output logic [RADIUS_W-1:0] radius_o
);

  localparam int unsigned XW = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;
  localparam int unsigned SQW = QUO_W + 2;

  logic             dv_q   [QUO_W+1];
  logic             ddeg_q [QUO_W+1];
  logic             dsat_q [QUO_W+1];
  logic [XW-1:0]    drem_q [QUO_W+1];
  logic [DEN_W-1:0] dden_q [QUO_W+1];
  logic [QUO_W-1:0] dquo_q [QUO_W+1];

  logic                sv_q    [RADIUS_W+1];
  logic                sdeg_q  [RADIUS_W+1];
  logic                ssat_q  [RADIUS_W+1];
  logic [SQW-1:0]      srem_q  [RADIUS_W+1];
  logic [RADIUS_W-1:0] sroot_q [RADIUS_W+1];

  logic                out_v_q;
  logic                out_deg_q;
  logic [RADIUS_W-1:0] out_rad_q;

  // entry: a radius of 2^32 or more means num >= den * 2^64
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en_i) begin
      dv_q[0] <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ddeg_q[0] <= ctl_i.degen;
      dsat_q[0] <= XW'(num_i) >= (XW'(den_i) << QUO_W);
      drem_q[0] <= XW'(num_i);
      dden_q[0] <= den_i;
      dquo_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    localparam int unsigned K = QUO_W - 1 - i;
    logic [XW-1:0] shd;
    logic          take;

    assign shd  = XW'(dden_q[i]) << K;
    assign take = drem_q[i] >= shd;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[i+1] <= 1'b0;
      end else if (en_i) begin
        dv_q[i+1] <= dv_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ddeg_q[i+1] <= ddeg_q[i];
        dsat_q[i+1] <= dsat_q[i];
        dden_q[i+1] <= dden_q[i];
        drem_q[i+1] <= take ? drem_q[i] - shd : drem_q[i];
        dquo_q[i+1] <= dquo_q[i] | (take ? (QUO_W'(1) << K) : '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0] <= 1'b0;
    end else if (en_i) begin
      sv_q[0] <= dv_q[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sdeg_q[0]  <= ddeg_q[QUO_W];
      ssat_q[0]  <= dsat_q[QUO_W];
      srem_q[0]  <= SQW'(dquo_q[QUO_W]);
      sroot_q[0] <= '0;
    end
  end

  // remainder holds q - root^2; try root + 2^b
  for (genvar j = 0; j < RADIUS_W; j++) begin : g_sqrt
    localparam int unsigned B = RADIUS_W - 1 - j;
    logic [SQW-1:0] trial;
    logic           take;

    assign trial = (SQW'(sroot_q[j]) << (B + 1)) | (SQW'(1) << (2 * B));
    assign take  = trial <= srem_q[j];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[j+1] <= 1'b0;
      end else if (en_i) begin
        sv_q[j+1] <= sv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sdeg_q[j+1]  <= sdeg_q[j];
        ssat_q[j+1]  <= ssat_q[j];
        srem_q[j+1]  <= take ? srem_q[j] - trial : srem_q[j];
        sroot_q[j+1] <= sroot_q[j] | (take ? (RADIUS_W'(1) << B) : '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_i) begin
      out_v_q <= sv_q[RADIUS_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_deg_q <= sdeg_q[RADIUS_W];
      out_rad_q <= (sdeg_q[RADIUS_W] || ssat_q[RADIUS_W]) ? '1 : sroot_q[RADIUS_W];
    end
  end

  assign ctl_o.valid = out_v_q;
  assign ctl_o.degen = out_deg_q;
  assign radius_o    = out_rad_q;

`ifndef SYNTH
  // a collinear triple has a zero divisor, so it always saturates
  a_degen_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[0] && ddeg_q[0] |-> dsat_q[0])
    else $error("degenerate item not saturated");

  // the quotient never reaches past its field once saturation is ruled out
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[QUO_W] && !dsat_q[QUO_W] |-> drem_q[QUO_W] < XW'(dden_q[QUO_W]))
    else $error("division remainder out of range");

  // sqrt remainder stays within 2*root
  a_sqrt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q[RADIUS_W] |-> srem_q[RADIUS_W] <= (SQW'(sroot_q[RADIUS_W]) << 1))
    else $error("square root remainder out of range");
`endif

endmodule

@@ src/triangle_circumradius.sv @@
// ----------------------------------------------------------------------------
// triangle_circumradius
// Circumradius of three Q16.16 points: floor(|AB||AC||BC| / (2|cross|)).
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_t*: one item is a point triple, packed in s_tdata_i.
//   Master channel m_t*: one item per input item, in order; m_tdata_o holds
//   the radius (unsigned, same fraction bits as the inputs), m_tuser_o is
//   set when the points are collinear or coincident (radius all ones).
//   A radius of 2^32 raw units or more saturates to all ones, flag clear.
//   The pipeline has 8 front stages (differences, 33x33 products,
//   sums, split wide multiplies), one saturation check, 64 division
//   stages (one quotient bit each), one square-root load stage and
//   32 square-root stages plus the output register. A new item enters
//   every cycle while the receiver does not stall.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and s_tready_o drops; nothing is lost or repeated.
//   Reset clears all valid bits; the pipeline is empty after reset.
// ----------------------------------------------------------------------------
module triangle_circumradius
  import tcr_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_tvalid_i,
  output logic                                  s_tready_o,
  // left_x, left_y, mid_x, mid_y, right_x, right_y, zero fill
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]    s_tdata_i,
  output logic                                  m_tvalid_o,
  input  logic                                  m_tready_i,
  // radius
  output logic [RADIUS_W-1:0]                   m_tdata_o,
  // degenerate
  output logic                                  m_tuser_o
);

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned DW   = W + 1;
  localparam int unsigned PW   = 2 * DW;
  localparam int unsigned SW   = PW + 1;
  localparam int unsigned DG   = (SW + 1) / 2;
  localparam int unsigned NW   = 3 * SW;
  localparam int unsigned DENW = 2 * SW + 2;

  logic     en;
  tcr_ctl_t ctl_in;
  tcr_ctl_t ctl_out;

  assign en         = !m_tvalid_o || m_tready_i;
  assign s_tready_o = en;

  // stage 1: coordinate differences as sign and magnitude
  logic signed [W-1:0]  crd [6];
  logic signed [DW-1:0] dif [6];
  logic [DW-1:0]        mag [6];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      crd[k] = s_tdata_i[k*W +: W];
    end
    dif[0] = DW'(crd[2]) - DW'(crd[0]);
    dif[1] = DW'(crd[3]) - DW'(crd[1]);
    dif[2] = DW'(crd[4]) - DW'(crd[0]);
    dif[3] = DW'(crd[5]) - DW'(crd[1]);
    dif[4] = DW'(crd[4]) - DW'(crd[2]);
    dif[5] = DW'(crd[5]) - DW'(crd[3]);
    for (int k = 0; k < 6; k++) begin
      mag[k] = dif[k][DW-1] ? DW'(-dif[k]) : DW'(dif[k]);
    end
  end

  logic          v1_q;
  logic [DW-1:0] mag1_q [6];
  logic [3:0]    neg1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag1_q <= mag;
      neg1_q <= {dif[3][DW-1], dif[2][DW-1], dif[1][DW-1], dif[0][DW-1]};
    end
  end

  // stage 2: cross terms and squares
  logic          v2_q;
  logic [PW-1:0] prd2_q [8];
  logic          pn2_q, qn2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      prd2_q[0] <= PW'(mag1_q[0]) * PW'(mag1_q[3]);
      prd2_q[1] <= PW'(mag1_q[1]) * PW'(mag1_q[2]);
      for (int k = 0; k < 6; k++) begin
        prd2_q[k+2] <= PW'(mag1_q[k]) * PW'(mag1_q[k]);
      end
      pn2_q <= neg1_q[0] ^ neg1_q[3];
      qn2_q <= neg1_q[1] ^ neg1_q[2];
    end
  end

  // stage 3: signed cross and squared side lengths
  logic                 v3_q;
  logic signed [SW:0]   xs3_q;
  logic [SW-1:0]        s3a_q, s3b_q, s3c_q;
  logic signed [SW:0]   pterm, qterm;

  assign pterm = pn2_q ? -$signed((SW+1)'(prd2_q[0])) : $signed((SW+1)'(prd2_q[0]));
  assign qterm = qn2_q ? -$signed((SW+1)'(prd2_q[1])) : $signed((SW+1)'(prd2_q[1]));

  always_ff @(posedge clk_i) begin
    if (en) begin
      xs3_q <= pterm - qterm;
      s3a_q <= SW'(prd2_q[2]) + SW'(prd2_q[3]);
      s3b_q <= SW'(prd2_q[4]) + SW'(prd2_q[5]);
      s3c_q <= SW'(prd2_q[6]) + SW'(prd2_q[7]);
    end
  end

  // stage 4: |cross|, degenerate flag
  logic          v4_q;
  logic [SW-1:0] cr4_q, s4a_q, s4b_q, s4c_q;
  logic          dg4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cr4_q <= xs3_q[SW] ? SW'(-xs3_q) : SW'(xs3_q);
      dg4_q <= xs3_q == '0;
      s4a_q <= s3a_q;
      s4b_q <= s3b_q;
      s4c_q <= s3c_q;
    end
  end

  // stage 5: partial products of s_ab = |AB|^2*|AC|^2 and cross^2
  logic [2*DG-1:0] ax5, bx5, cx5;
  logic            v5_q;
  logic [2*DG-1:0] ppab5_q [2][2];
  logic [2*DG-1:0] ppcc5_q [2][2];
  logic [SW-1:0]   s5c_q;
  logic            dg5_q;

  assign ax5 = (2*DG)'(s4a_q);
  assign bx5 = (2*DG)'(s4b_q);
  assign cx5 = (2*DG)'(cr4_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          ppab5_q[i][j] <= (2*DG)'(ax5[i*DG +: DG]) * (2*DG)'(bx5[j*DG +: DG]);
          ppcc5_q[i][j] <= (2*DG)'(cx5[i*DG +: DG]) * (2*DG)'(cx5[j*DG +: DG]);
        end
      end
      s5c_q <= s4c_q;
      dg5_q <= dg4_q;
    end
  end

  // stage 6: sum partial products
  logic [2*SW-1:0] ab_sum, cc_sum;

  always_comb begin
    ab_sum = '0;
    cc_sum = '0;
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        ab_sum = ab_sum + ((2*SW)'(ppab5_q[i][j]) << ((i + j) * DG));
        cc_sum = cc_sum + ((2*SW)'(ppcc5_q[i][j]) << ((i + j) * DG));
      end
    end
  end

  logic            v6_q;
  logic [2*SW-1:0] ab6_q, cc6_q;
  logic [SW-1:0]   s6c_q;
  logic            dg6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ab6_q <= ab_sum;
      cc6_q <= cc_sum;
      s6c_q <= s5c_q;
      dg6_q <= dg5_q;
    end
  end

  // stage 7: partial products of num = s_ab * |BC|^2; den = 4*cross^2
  logic [4*DG-1:0] ab7x;
  logic [2*DG-1:0] c7x;
  logic            v7_q;
  logic [2*DG-1:0] ppn7_q [4][2];
  logic [DENW-1:0] den7_q;
  logic            dg7_q;

  assign ab7x = (4*DG)'(ab6_q);
  assign c7x  = (2*DG)'(s6c_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 2; j++) begin
          ppn7_q[i][j] <= (2*DG)'(ab7x[i*DG +: DG]) * (2*DG)'(c7x[j*DG +: DG]);
        end
      end
      den7_q <= DENW'(cc6_q) << 2;
      dg7_q  <= dg6_q;
    end
  end

  // stage 8: sum into num
  logic [NW-1:0] num_sum;

  always_comb begin
    num_sum = '0;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 2; j++) begin
        num_sum = num_sum + (NW'(ppn7_q[i][j]) << ((i + j) * DG));
      end
    end
  end

  logic            v8_q;
  logic [NW-1:0]   num8_q;
  logic [DENW-1:0] den8_q;
  logic            dg8_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      num8_q <= num_sum;
      den8_q <= den7_q;
      dg8_q  <= dg7_q;
    end
  end

  // valid bits of the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_tvalid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  assign ctl_in.valid = v8_q;
  assign ctl_in.degen = dg8_q;

  tcr_root #(
    .NUM_W (NW),
    .DEN_W (DENW)
  ) u_root (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .ctl_i    (ctl_in),
    .num_i    (num8_q),
    .den_i    (den8_q),
    .ctl_o    (ctl_out),
    .radius_o (m_tdata_o)
  );

  assign m_tvalid_o = ctl_out.valid;
  assign m_tuser_o  = ctl_out.degen;

`ifndef SYNTH
  a_degen_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o |-> m_tdata_o == '1)
    else $error("degenerate result without saturated radius");

  a_zero_cross: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q && dg5_q |-> ppcc5_q[0][0] == '0 && ppcc5_q[1][1] == '0)
    else $error("degenerate flag with nonzero cross");

  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && !$past(s_tready_o))
    else $error("pipeline advanced during stall");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Streams point triples through triangle_circumradius and checks every
// radius and degenerate flag against an exact wide-integer prediction,
// with random idling on both sides, a long output stall and a drain pause.
// ----------------------------------------------------------------------------
module tb_top;
  import tcr_pkg::*;

  localparam int unsigned CW        = 32;
  localparam int unsigned TDATA_W   = ((6 * CW + 7) / 8) * 8;
  localparam int unsigned N_RANDOM  = 700;
  localparam int unsigned LATENCY   = 107;
  localparam int unsigned CYC_LIMIT = 400000;
  localparam int unsigned HOLD_LEN  = 400;

  typedef struct packed {
    logic [CW-1:0] cy;
    logic [CW-1:0] cx;
    logic [CW-1:0] by;
    logic [CW-1:0] bx;
    logic [CW-1:0] ay;
    logic [CW-1:0] ax;
  } triple_t;

  typedef struct packed {
    logic [RADIUS_W-1:0] radius;
    logic                degen;
  } circle_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_tvalid_i;
  logic                s_tready_o;
  logic [TDATA_W-1:0]  s_tdata_i;
  logic                m_tvalid_o;
  logic                m_tready_i;
  logic [RADIUS_W-1:0] m_tdata_o;
  logic                m_tuser_o;

  triple_t     pending_q[$];
  circle_t     radius_due[$];
  int unsigned n_sent;
  int unsigned n_bad;
  int unsigned n_cycles;
  int unsigned hold_cnt;
  logic        hold_done;
  logic        taken;

  triangle_circumradius u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // floor of |AB||AC||BC| / (2|cross|), found bit by bit on exact squares
  function automatic circle_t circumradius_of(triple_t t);
    logic signed [79:0]  dbx, dby, dcx, dcy, ex, ey, crs;
    logic [255:0]        mc, lab, lac, lbc, num, den, cand_sq;
    logic [RADIUS_W-1:0] r, cand;
    circle_t             res;
    dbx = 80'($signed(t.bx)) - 80'($signed(t.ax));
    dby = 80'($signed(t.by)) - 80'($signed(t.ay));
    dcx = 80'($signed(t.cx)) - 80'($signed(t.ax));
    dcy = 80'($signed(t.cy)) - 80'($signed(t.ay));
    ex  = 80'($signed(t.cx)) - 80'($signed(t.bx));
    ey  = 80'($signed(t.cy)) - 80'($signed(t.by));
    crs = dbx * dcy - dby * dcx;
    if (crs == 0) begin
      res.radius = '1;
      res.degen  = 1'b1;
      return res;
    end
    mc  = 256'(crs < 0 ? -crs : crs);
    lab = 256'(dbx * dbx + dby * dby);
    lac = 256'(dcx * dcx + dcy * dcy);
    lbc = 256'(ex * ex + ey * ey);
    num = lab * lac * lbc;
    den = 256'(4) * mc * mc;
    r = '0;
    for (int b = RADIUS_W - 1; b >= 0; b--) begin
      cand = r | (RADIUS_W'(1) << b);
      cand_sq = 256'(cand) * 256'(cand) * den;
      if (cand_sq <= num) r = cand;
    end
    res.radius = r;
    res.degen  = 1'b0;
    return res;
  endfunction

  function automatic triple_t make_triple(logic [CW-1:0] ax, logic [CW-1:0] ay,
                                          logic [CW-1:0] bx, logic [CW-1:0] by,
                                          logic [CW-1:0] cx, logic [CW-1:0] cy);
    triple_t t;
    t.ax = ax; t.ay = ay; t.bx = bx; t.by = by; t.cx = cx; t.cy = cy;
    return t;
  endfunction

  // coordinate near a random center, span chosen so radii mostly fit
  function automatic logic [CW-1:0] near(logic [CW-1:0] base, int unsigned span);
    return base + CW'($urandom_range(2 * span, 0)) - CW'(span);
  endfunction

  function automatic int unsigned pick_span();
    case ($urandom_range(3, 0))
      0: return 16;
      1: return 1 << 12;
      2: return 1 << 20;
      default: return 1 << 28;
    endcase
  endfunction

  // sender
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid_i <= 1'b0;
      s_tdata_i  <= '0;
    end else if (!s_tvalid_i || taken) begin
      if (pending_q.size() != 0 &&
          ((n_sent > 400 && n_sent < 520) || $urandom_range(99, 0) >= 18)) begin
        s_tvalid_i <= 1'b1;
        s_tdata_i  <= TDATA_W'(pending_q.pop_front());
      end else begin
        s_tvalid_i <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off once the pipeline is busy
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready_i <= 1'b0;
      hold_cnt   <= 0;
      hold_done  <= 1'b0;
    end else if (!hold_done && n_sent >= 150) begin
      m_tready_i <= 1'b0;
      hold_cnt   <= hold_cnt + 1;
      if (hold_cnt == HOLD_LEN) hold_done <= 1'b1;
    end else begin
      m_tready_i <= (n_sent > 400 && n_sent < 520) || $urandom_range(99, 0) >= 18;
    end
  end

  // check outputs and record accepted inputs
  always @(posedge clk_i or negedge rst_ni) begin
    circle_t want;
    triple_t t;
    if (!rst_ni) begin
      taken    = 1'b0;
      n_sent   = 0;
      n_bad    = 0;
      n_cycles = 0;
    end else begin
      n_cycles = n_cycles + 1;
      if (n_cycles > CYC_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
      taken = s_tvalid_i && s_tready_o;
      if (taken) begin
        t = triple_t'(s_tdata_i[6*CW-1:0]);
        radius_due.push_back(circumradius_of(t));
        n_sent = n_sent + 1;
      end
      if (m_tvalid_o && m_tready_i) begin
        if (radius_due.size() == 0) begin
          n_bad = n_bad + 1;
          if (n_bad <= 10)
            $display("unexpected result: radius %h degen %b", m_tdata_o, m_tuser_o);
        end else begin
          want = radius_due.pop_front();
          if (want.radius !== m_tdata_o || want.degen !== m_tuser_o) begin
            n_bad = n_bad + 1;
            if (n_bad <= 10)
              $display("mismatch: radius exp %h got %h, degen exp %b got %b",
                       want.radius, m_tdata_o, want.degen, m_tuser_o);
          end
        end
      end
    end
  end

  task automatic drain();
    while (pending_q.size() != 0 || s_tvalid_i) @(posedge clk_i);
    while (radius_due.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [CW-1:0] cx0, cy0;
    int unsigned   span;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // coincident, collinear, unit shapes, extremes and saturation
    pending_q.push_back(make_triple(0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_triple('1, '1, '1, '1, '1, '1));
    pending_q.push_back(make_triple(0, 0, 32'h10000, 32'h10000, 32'h20000, 32'h20000));
    pending_q.push_back(make_triple(0, 0, 32'h10000, 0, 0, 32'h10000));
    pending_q.push_back(make_triple(0, 0, 1, 0, 0, 1));
    pending_q.push_back(make_triple(0, 0, 1, 0, 0, 0));
    pending_q.push_back(make_triple(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                                    32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
    pending_q.push_back(make_triple(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                                    32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
    pending_q.push_back(make_triple(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                                    32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    pending_q.push_back(make_triple(32'h8000_0000, 0, 32'h7fff_ffff, 0, 0, 1));
    pending_q.push_back(make_triple(32'h8000_0000, 0, 32'h7fff_ffff, 0, 0, 32'h7fff_ffff));
    pending_q.push_back(make_triple(0, 0, 32'h10000, 0, 32'h20000, 1));
    pending_q.push_back(make_triple(32'hffff_0000, 32'h0001_0000, 32'h0001_0000,
                                    32'h0001_0000, 0, 32'hffff_0000));
    pending_q.push_back(make_triple(5, 7, 5, 7, 9, 3));
    pending_q.push_back(make_triple(32'h1234_5678, 32'h8765_4321, 32'h1234_5679,
                                    32'h8765_4322, 32'h1234_5680, 32'h8765_4321));
    drain();

    for (int i = 0; i < N_RANDOM; i++) begin
      case ($urandom_range(9, 0))
        0, 1:
          pending_q.push_back(make_triple($urandom, $urandom, $urandom,
                                          $urandom, $urandom, $urandom));
        2: begin
          // collinear: C = A + k*(B - A)
          cx0 = $urandom;
          cy0 = $urandom;
          span = pick_span();
          pending_q.push_back(make_triple(cx0, cy0, cx0 + CW'(span), cy0 + 7,
                                          cx0 + CW'(3 * span), cy0 + 21));
        end
        default: begin
          cx0 = $urandom;
          cy0 = $urandom;
          span = pick_span();
          pending_q.push_back(make_triple(near(cx0, span), near(cy0, span),
                                          near(cx0, span), near(cy0, span),
                                          near(cx0, span), near(cy0, span)));
        end
      endcase
      if (i == 350) drain();
    end
    drain();
    repeat (LATENCY + 20) @(posedge clk_i);
    if (n_bad == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

@@ triangle_circumradius.f @@
src/tcr_pkg.sv
src/tcr_root.sv
src/triangle_circumradius.sv
tb/tb_top.sv
